// ===== design/wacsa_pkg.sv =====
// Package for the wide accumulator shifted add unit.
// Holds sizes, the queue entry type and the engine state type. No dependencies.
package wacsa_pkg;

   localparam int WORD_BITS = 30;
   localparam int WORDS     = 1024;

   localparam int POS_W  = 15;
   localparam int ADD_W  = 31;
   localparam int ADDR_W = $clog2(WORDS);
   localparam int CUR_W  = ADDR_W + 1;
   localparam int SH_W   = $clog2(WORD_BITS);
   localparam int VAL_W  = ADD_W + WORD_BITS;
   localparam int RS     = 24;
   localparam int RECIP  = (2 ** RS) / WORD_BITS;
   localparam int RECIP_W = RS + 1;
   localparam int QDEPTH = 2;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic             op;
      logic             neg;
      logic [POS_W-1:0] idx;
      logic [SH_W-1:0]  sh;
      logic [VAL_W-1:0] val;
   } q_entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUERY,
      ST_ADD
   } eng_state_type;

endpackage

// ===== design/wacsa_front.sv =====
// Front part: splits the bit position into word index and shift, aligns the
// addend magnitude, and holds decoded items in a two-entry queue. Uses wacsa_pkg.
module wacsa_front import wacsa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic                    op,
   input  logic signed [ADD_W-1:0] addend,
   input  logic [POS_W-1:0]        bit_position,
   input  logic                    pop,
   output logic                    full,
   output logic                    q_valid,
   output q_entry_type             q_head
);

   q_entry_type qmem [QDEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   logic [POS_W+RECIP_W-1:0] prod;
   logic [POS_W-1:0]         est;
   logic [POS_W-1:0]         rem_raw;
   logic [ADD_W-1:0]         mag;
   logic                     neg;
   q_entry_type              ent;

   always_comb begin
      prod    = POS_W'(bit_position) * RECIP_W'(RECIP);
      est     = prod[RS +: POS_W];
      rem_raw = bit_position - POS_W'(est * POS_W'(WORD_BITS));
      neg     = addend[ADD_W-1];
      mag     = neg ? (~addend + ADD_W'(1)) : addend;
      ent.op  = op;
      ent.neg = neg;
      if (rem_raw >= POS_W'(WORD_BITS)) begin
         ent.idx = est + POS_W'(1);
         ent.sh  = SH_W'(rem_raw - POS_W'(WORD_BITS));
      end else begin
         ent.idx = est;
         ent.sh  = SH_W'(rem_raw);
      end
      ent.val = VAL_W'(mag) << ent.sh;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         qmem[wr_ptr_ff] <= ent;
      end
   end

   assign full    = (count_ff == 2'(QDEPTH));
   assign q_valid = (count_ff != '0);
   assign q_head  = qmem[rd_ptr_ff];

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid) else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QDEPTH)) else $error("queue count overflow");

endmodule

// ===== design/wacsa_back.sv =====
// Back part: word memory and the read-modify-write engine that adds the
// aligned value word by word, runs carries, and answers bit queries. Uses wacsa_pkg.
module wacsa_back import wacsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  q_entry_type q_head,
   output logic        pop,
   output logic        clearing,
   output logic        rsp_valid,
   output logic        rsp_bit_value
);

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   eng_state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [CUR_W-1:0]  cur_ff, cur_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic              cy_ff, cy_in;
   logic              neg_ff, neg_in;
   logic [SH_W-1:0]   sh_ff, sh_in;

   logic                 in_range;
   logic                 rd_en, wr_en;
   logic [ADDR_W-1:0]    rd_addr, wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS:0]   step;
   logic [WORD_BITS:0]   chunk;
   logic [VAL_W-1:0]     val_n;
   logic                 cy_n;
   logic [CUR_W-1:0]     nxt;
   logic                 more;

   always_comb begin
      in_range = (q_head.idx < POS_W'(WORDS));
      chunk    = {1'b0, val_ff[WORD_BITS-1:0]} + (WORD_BITS+1)'(cy_ff);
      if (neg_ff) begin
         step = {1'b0, rd_data_ff} - chunk;
      end else begin
         step = {1'b0, rd_data_ff} + chunk;
      end
      cy_n  = step[WORD_BITS];
      val_n = val_ff >> WORD_BITS;
      nxt   = cur_ff + CUR_W'(1);
      more  = (nxt < CUR_W'(WORDS)) && ((val_n != '0) || cy_n);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_W'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid && in_range) begin
               state_in = (q_head.op == OP_QUERY) ? ST_QUERY : ST_ADD;
            end
         end
         ST_QUERY: state_in = ST_IDLE;
         ST_ADD: begin
            if (!more) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop           = 1'b0;
      clearing      = 1'b0;
      rsp_valid     = 1'b0;
      rsp_bit_value = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = q_head.idx[ADDR_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = cur_ff[ADDR_W-1:0];
      wr_data       = step[WORD_BITS-1:0];
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      val_in        = val_ff;
      cy_in         = cy_ff;
      neg_in        = neg_ff;
      sh_in         = sh_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
            wr_en    = 1'b1;
            wr_addr  = clr_ff;
            wr_data  = '0;
            clr_in   = clr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (q_valid) begin
               pop    = 1'b1;
               rd_en  = in_range;
               cur_in = CUR_W'(q_head.idx[ADDR_W-1:0]);
               val_in = q_head.val;
               cy_in  = 1'b0;
               neg_in = q_head.neg;
               sh_in  = q_head.sh;
               if (q_head.op == OP_QUERY && !in_range) begin
                  rsp_valid = 1'b1;
               end
            end
         end
         ST_QUERY: begin
            rsp_valid     = 1'b1;
            rsp_bit_value = rd_data_ff[sh_ff];
         end
         ST_ADD: begin
            wr_en   = 1'b1;
            rd_en   = more;
            rd_addr = nxt[ADDR_W-1:0];
            cur_in  = nxt;
            val_in  = val_n;
            cy_in   = cy_n;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      val_ff <= val_in;
      cy_ff  <= cy_in;
      neg_ff <= neg_in;
      sh_ff  <= sh_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      pop |-> !clearing) else $error("item taken during clearing pass");
   a_add_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD |-> cur_ff < CUR_W'(WORDS)) else $error("word index out of range");
   a_query_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_QUERY |-> rsp_valid && !pop) else $error("query without response");

endmodule

// ===== design/wide_accumulator_shifted_add_unit.sv =====
// Top level of the wide accumulator shifted add unit.
// Instantiates wacsa_front and wacsa_back; uses wacsa_pkg.
//
// Usage:
//   Request channel: an item is taken at a clock edge with start high and
//   busy low. req_op selects add (shifted signed addend) or single-bit query.
//   Response channel: a query returns one item, rsp_valid high for exactly
//   one cycle with rsp_bit_value; adds return nothing. The receiver cannot
//   stall, so responses are never held.
//   Flow: an item is registered in the decode queue before the engine can
//   take it. A query in range answers in the cycle after it leaves the queue
//   (memory read is registered); one beyond the top answers on the pop cycle
//   with 0. An add is popped, then written word by word: the aligned value
//   covers one or two words, and each carry or borrow ripples on through
//   further words, up to the top word of memory. The engine's word
//   read-modify-write port handles one word at a time.
//   The two-entry queue lets new items enter while the engine works.
//   Reset: a clearing pass zeroes all WORDS (1024) words of the memory;
//   busy stays high until it ends.
module wide_accumulator_shifted_add_unit import wacsa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_op,
   input  logic signed [ADD_W-1:0] req_addend,
   input  logic [POS_W-1:0]        req_bit_position,
   output logic                    rsp_valid,
   output logic                    rsp_bit_value
);

   logic        push;
   logic        full;
   logic        clearing;
   logic        pop;
   logic        q_valid;
   q_entry_type q_head;

   assign busy = full | clearing;
   assign push = start & ~busy;

   wacsa_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .op           (req_op),
      .addend       (req_addend),
      .bit_position (req_bit_position),
      .pop          (pop),
      .full         (full),
      .q_valid      (q_valid),
      .q_head       (q_head)
   );

   wacsa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_bit_value (rsp_bit_value)
   );

endmodule
